// File: design/tijm_pkg.sv
// shared types and constants for the tick interval jitter monitor
package tijm_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned AGE_W  = 4;

   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 160;

   localparam logic [WORD_W-1:0] MIN_RESET = {WORD_W{1'b1}};

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_READ = 1'b1
   } op_type;

   // statistics as reported for the current transaction, after any update
   typedef struct packed {
      logic              delta_valid;
      logic [WORD_W-1:0] interval;
      logic [WORD_W-1:0] min_interval;
      logic [WORD_W-1:0] max_interval;
      logic [WORD_W-1:0] interval_count;
   } stats_type;

endpackage

// File: design/tijm_cell.sv
// one history cell: holds one interval and hands it to the next older cell
module tijm_cell #(
   parameter int unsigned CELL_INDEX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         shift_en,
   input  logic [tijm_pkg::WORD_W-1:0]  data_in,
   input  logic [tijm_pkg::AGE_W-1:0]   age_sel,
   output logic [tijm_pkg::WORD_W-1:0]  data_out,
   output logic [tijm_pkg::WORD_W-1:0]  sel_out
);
   import tijm_pkg::*;

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in_mux;

   assign data_in_mux = shift_en ? data_in : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in_mux;
      end
   end

   assign data_out = data_ff;
   // only the cell whose age matches drives its value onto the or-tree
   assign sel_out  = (32'(age_sel) == 32'(CELL_INDEX)) ? data_ff : '0;

endmodule

// File: design/tijm_stats.sv
// interval computation and running min, max and count
module tijm_stats (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         tick_en,
   input  logic [tijm_pkg::WORD_W-1:0]  stamp,
   output tijm_pkg::stats_type          stats
);
   import tijm_pkg::*;

   logic [WORD_W-1:0] prev_ff;
   logic              have_prev_ff;
   logic [WORD_W-1:0] min_ff;
   logic [WORD_W-1:0] max_ff;
   logic [WORD_W-1:0] count_ff;

   logic [WORD_W-1:0] delta;
   logic              record;
   logic [WORD_W-1:0] min_in;
   logic [WORD_W-1:0] max_in;
   logic [WORD_W-1:0] count_in;

   always_comb begin
      delta    = stamp - prev_ff;
      record   = tick_en && have_prev_ff;
      min_in   = (record && (delta < min_ff)) ? delta : min_ff;
      max_in   = (record && (delta > max_ff)) ? delta : max_ff;
      count_in = record ? count_ff + WORD_W'(1) : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         min_ff       <= MIN_RESET;
         max_ff       <= '0;
         count_ff     <= '0;
      end else begin
         if (tick_en) begin
            prev_ff      <= stamp;
            have_prev_ff <= 1'b1;
         end
         min_ff   <= min_in;
         max_ff   <= max_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      stats.delta_valid    = record;
      stats.interval       = record ? delta : '0;
      stats.min_interval   = min_in;
      stats.max_interval   = max_in;
      stats.interval_count = count_in;
   end

endmodule

// File: design/tick_interval_jitter_monitor.sv
// top level of the tick interval jitter monitor
// a result is registered into the output register, or into the skid while the output register holds one
// throughput: one transaction per cycle while the skid is empty, set by the combinational stats and cell shift
// a two-entry output stage (output register plus skid) keeps req_tready up while one waits
// reset: synchronous, clears statistics, first-sample flag and every history cell at once
// the history cells are a shift chain, cell 0 holding the newest interval
module tick_interval_jitter_monitor #(
   parameter int unsigned HISTORY_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tijm_pkg::REQ_DATA_W-1:0]   req_tdata,  // timestamp[31:0], age[35:32], zero pad
   input  logic                              req_tuser,  // operation: 0 tick, 1 history read
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tijm_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // interval, min_interval,
                                                         // max_interval, interval_count,
                                                         // history_value (32 bits each)
   output logic                              rsp_tuser   // delta_valid
);
   import tijm_pkg::*;

   // request decode
   logic              req_accept;
   logic [WORD_W-1:0] req_stamp;
   logic [AGE_W-1:0]  req_age;
   logic [AGE_W-1:0]  age_mod;
   logic [AGE_W-1:0]  age_wrap [2**AGE_W];
   op_type            req_op;
   logic              tick_en;

   assign req_accept = req_tvalid && req_tready;
   assign req_stamp  = req_tdata[WORD_W-1:0];
   assign req_age    = req_tdata[WORD_W+AGE_W-1:WORD_W];
   assign req_op     = op_type'(req_tuser);
   assign tick_en    = req_accept && (req_op == OP_TICK);

   // ages beyond the ring wrap round it: a constant table over every age code
   for (genvar a = 0; a < 2**AGE_W; a++) begin : g_age_wrap
      assign age_wrap[a] = AGE_W'(a % HISTORY_DEPTH);
   end
   assign age_mod = age_wrap[req_age];

   // statistics unit
   stats_type stats;

   tijm_stats u_stats (
      .clock   (clock),
      .reset   (reset),
      .tick_en (tick_en),
      .stamp   (req_stamp),
      .stats   (stats)
   );

   // history chain: shifts one place on each recorded interval
   logic [WORD_W-1:0] cell_data [HISTORY_DEPTH];
   logic [WORD_W-1:0] cell_sel  [HISTORY_DEPTH];

   for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
      logic [WORD_W-1:0] link_in;
      if (g == 0) begin : g_head
         assign link_in = stats.interval;
      end else begin : g_body
         assign link_in = cell_data[g-1];
      end
      tijm_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (stats.delta_valid),
         .data_in  (link_in),
         .age_sel  (age_mod),
         .data_out (cell_data[g]),
         .sel_out  (cell_sel[g])
      );
   end

   // or-tree over the cells; zero on ticks
   logic [WORD_W-1:0] hist_or;
   logic [WORD_W-1:0] hist_value;

   always_comb begin
      hist_or = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         hist_or = hist_or | cell_sel[i];
      end
      hist_value = (req_op == OP_READ) ? hist_or : '0;
   end

   // packed response for this transaction
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic                  rsp_user_in;

   assign rsp_data_in = {hist_value, stats.interval_count, stats.max_interval,
                         stats.min_interval, stats.interval};
   assign rsp_user_in = stats.delta_valid;

   // output register plus skid
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic                  out_user_ff;
   logic                  skid_valid_ff;
   logic [RSP_DATA_W-1:0] skid_data_ff;
   logic                  skid_user_ff;
   logic                  rsp_pop;

   assign rsp_pop    = out_valid_ff && rsp_tready;
   assign req_tready = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // no new transaction can arrive while the skid is full
         if (rsp_pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept) begin
         if (out_valid_ff && !rsp_pop) begin
            skid_valid_ff <= 1'b1;
         end
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            out_data_ff <= skid_data_ff;
            out_user_ff <= skid_user_ff;
         end
      end else if (req_accept) begin
         if (out_valid_ff && !rsp_pop) begin
            skid_data_ff <= rsp_data_in;
            skid_user_ff <= rsp_user_in;
         end else begin
            out_data_ff <= rsp_data_in;
            out_user_ff <= rsp_user_in;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // minimum-versus-maximum check taken from the reported statistics
   logic u_stats_min_le_max;
   assign u_stats_min_le_max = (stats.min_interval <= stats.max_interval);

`ifndef SYNTH
   // a held skid entry always sits behind a held output entry
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a transaction while the output register is empty");

   // once an interval is recorded the running minimum never exceeds the maximum
   assert property (@(posedge clock) disable iff (reset)
      stats.delta_valid |=> (u_stats_min_le_max))
      else $error("running minimum above running maximum");

   // history reads never report an interval
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == OP_READ)) |-> !stats.delta_valid)
      else $error("interval reported on a history read");
`endif

endmodule
